// ===== hdl/gnss_receiver_init_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// gnss receiver init sequencer assertion macros
// concurrent check shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef GNSS_RECEIVER_INIT_SEQUENCER_ASSERT_SVH
`define GNSS_RECEIVER_INIT_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define GRIS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gris same-cycle check failed");

// next-cycle implication
`define GRIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gris next-cycle check failed");

`endif

// ===== hdl/gris_pkg.sv =====
// ----------------------------------------------------------------------------
// gris_pkg
// types, codes and reset values of the gnss receiver init sequencer
// ----------------------------------------------------------------------------
package gris_pkg;

  localparam int MAX_INIT_STRINGS = 16;
  localparam int STR_IDX_W        = 5;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [3:0] {
    ST_RESET  = 4'd0,
    ST_PAUSE0 = 4'd1,
    ST_BREAK1 = 4'd2,
    ST_PAUSE1 = 4'd3,
    ST_BREAK2 = 4'd4,
    ST_PAUSE2 = 4'd5,
    ST_COM1   = 4'd6,
    ST_PAUSE3 = 4'd7,
    ST_COM2   = 4'd8,
    ST_INIT   = 4'd9,
    ST_IDLE   = 4'd10
  } seq_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_WAIT   = 3'd0,
    REG_REPLY_WAIT   = 3'd1,
    REG_LONG_PAUSE   = 3'd2,
    REG_BREAK        = 3'd3,
    REG_MID_PAUSE    = 3'd4,
    REG_SHORT_PAUSE  = 3'd5,
    REG_STRING_COUNT = 3'd6
  } cfg_reg_e;

  localparam logic [1:0] BRK_NONE   = 2'd0;
  localparam logic [1:0] BRK_START  = 2'd1;
  localparam logic [1:0] BRK_END    = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_COM1   = 2'd1;
  localparam logic [1:0] CMD_COM2   = 2'd2;
  localparam logic [1:0] APPLY_NONE = 2'd0;
  localparam logic [1:0] APPLY_COM1 = 2'd1;
  localparam logic [1:0] APPLY_COM2 = 2'd2;

  localparam logic [31:0] RST_RESET_WAIT  = 32'd800000000;
  localparam logic [31:0] RST_REPLY_WAIT  = 32'd100000000;
  localparam logic [31:0] RST_LONG_PAUSE  = 32'd1000000000;
  localparam logic [31:0] RST_BREAK       = 32'd25000000;
  localparam logic [31:0] RST_MID_PAUSE   = 32'd150000000;
  localparam logic [31:0] RST_SHORT_PAUSE = 32'd50000000;
  localparam logic [STR_IDX_W-1:0] RST_STRING_COUNT = '0;

  typedef struct packed {
    logic [31:0] now;
    logic        com_reply_seen;
    logic [15:0] prompt_count;
    logic        position_msg_seen;
  } poll_t;

  typedef struct packed {
    logic [3:0] fsm_state;
    logic       init_ports;
    logic       release_reset;
    logic [1:0] break_control;
    logic [1:0] send_baud_cmd;
    logic [1:0] apply_baud;
    logic       send_init;
    logic [3:0] init_index;
    logic       ready_res;
  } result_t;

  typedef struct packed {
    logic [31:0]          reset_wait_cycles;
    logic [31:0]          reply_wait_cycles;
    logic [31:0]          long_pause_cycles;
    logic [31:0]          break_cycles;
    logic [31:0]          mid_pause_cycles;
    logic [31:0]          short_pause_cycles;
    logic [STR_IDX_W-1:0] init_string_count;
  } cfg_t;

  typedef struct packed {
    seq_state_e           state;
    logic                 entering;
    logic [31:0]          deadline;
    logic [STR_IDX_W-1:0] string_index;
    logic [15:0]          prompt_mark;
  } seq_t;

endpackage

// ===== hdl/gris_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gris_cfg_regs
// timing and string count registers behind the configuration write port
// ----------------------------------------------------------------------------
module gris_cfg_regs
  import gris_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  // writes must only land while the sequencer is quiet; not enforced here, and no back-pressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_wait_cycles  <= RST_RESET_WAIT;
      cfg.reply_wait_cycles  <= RST_REPLY_WAIT;
      cfg.long_pause_cycles  <= RST_LONG_PAUSE;
      cfg.break_cycles       <= RST_BREAK;
      cfg.mid_pause_cycles   <= RST_MID_PAUSE;
      cfg.short_pause_cycles <= RST_SHORT_PAUSE;
      cfg.init_string_count  <= RST_STRING_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_WAIT:   cfg.reset_wait_cycles  <= cfg_data;
        REG_REPLY_WAIT:   cfg.reply_wait_cycles  <= cfg_data;
        REG_LONG_PAUSE:   cfg.long_pause_cycles  <= cfg_data;
        REG_BREAK:        cfg.break_cycles       <= cfg_data;
        REG_MID_PAUSE:    cfg.mid_pause_cycles   <= cfg_data;
        REG_SHORT_PAUSE:  cfg.short_pause_cycles <= cfg_data;
        REG_STRING_COUNT: cfg.init_string_count  <= cfg_data[STR_IDX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/gris_step.sv =====
// ----------------------------------------------------------------------------
// gris_step
// next state, deadline arming and action decode for one poll
// ----------------------------------------------------------------------------
module gris_step
  import gris_pkg::*;
(
  input  seq_t    cur,
  input  poll_t   poll,
  input  cfg_t    cfg,
  output seq_t    nxt,
  output result_t res
);

  localparam logic [STR_IDX_W-1:0] MAX_STR = STR_IDX_W'(MAX_INIT_STRINGS);

  logic                 reached;
  logic                 arm;
  logic [31:0]          arm_cycles;
  logic [31:0]          elapsed;
  logic [STR_IDX_W-1:0] idx;
  logic [STR_IDX_W-1:0] limit;
  seq_state_e           st_next;

  // signed wrap compare against the armed deadline
  assign elapsed = poll.now - cur.deadline;
  assign reached = ~elapsed[31];
  assign limit   = (cfg.init_string_count > MAX_STR) ? MAX_STR : cfg.init_string_count;
  assign idx     = cur.entering ? '0 : cur.string_index;

  always_comb begin
    st_next          = cur.state;
    arm              = 1'b0;
    arm_cycles       = cfg.short_pause_cycles;
    nxt.string_index = cur.string_index;
    nxt.prompt_mark  = cur.prompt_mark;
    res              = '0;
    case (cur.state)
      ST_RESET: begin
        if (cur.entering) begin
          res.init_ports = 1'b1;
          arm            = 1'b1;
          arm_cycles     = cfg.reset_wait_cycles;
        end else if (reached) begin
          res.release_reset = 1'b1;
          st_next           = ST_PAUSE0;
        end
      end
      ST_PAUSE0, ST_PAUSE1, ST_PAUSE2, ST_PAUSE3: begin
        case (cur.state)
          ST_PAUSE0: arm_cycles = cfg.long_pause_cycles;
          ST_PAUSE1: arm_cycles = cfg.mid_pause_cycles;
          default:   arm_cycles = cfg.short_pause_cycles;
        endcase
        if (cur.entering) begin
          arm = 1'b1;
        end else if (reached) begin
          case (cur.state)
            ST_PAUSE0: st_next = ST_BREAK1;
            ST_PAUSE1: st_next = ST_BREAK2;
            ST_PAUSE2: st_next = ST_COM1;
            default:   st_next = ST_COM2;
          endcase
        end
      end
      ST_BREAK1, ST_BREAK2: begin
        arm_cycles = cfg.break_cycles;
        if (cur.entering) begin
          arm               = 1'b1;
          res.break_control = BRK_START;
        end else if (reached) begin
          res.break_control = BRK_END;
          st_next           = (cur.state == ST_BREAK1) ? ST_PAUSE1 : ST_PAUSE2;
        end
      end
      ST_COM1, ST_COM2: begin
        arm_cycles = cfg.reply_wait_cycles;
        if (cur.entering) begin
          arm               = 1'b1;
          res.send_baud_cmd = (cur.state == ST_COM1) ? CMD_COM1 : CMD_COM2;
        end else if (poll.com_reply_seen) begin
          // a reply on the deadline poll still counts as a pass
          res.apply_baud = (cur.state == ST_COM1) ? APPLY_COM1 : APPLY_COM2;
          st_next        = (cur.state == ST_COM1) ? ST_PAUSE3 : ST_INIT;
        end else if (reached) begin
          st_next = ST_RESET;
        end
      end
      ST_INIT: begin
        arm_cycles       = cfg.reply_wait_cycles;
        nxt.string_index = idx;
        if (cur.entering || (poll.prompt_count != cur.prompt_mark)) begin
          if (idx < limit) begin
            arm              = 1'b1;
            nxt.prompt_mark  = poll.prompt_count;
            res.send_init    = 1'b1;
            res.init_index   = idx[3:0];
            nxt.string_index = idx + 1'b1;
          end else begin
            st_next = ST_IDLE;
          end
        end else if (reached) begin
          st_next = ST_RESET;
        end
      end
      ST_IDLE: begin
        // watchdog rearmed by every position message
        arm_cycles = cfg.long_pause_cycles;
        if (cur.entering || poll.position_msg_seen) begin
          arm = 1'b1;
        end else if (reached) begin
          st_next = ST_RESET;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase

    nxt.state     = st_next;
    nxt.entering  = (st_next != cur.state);
    nxt.deadline  = arm ? (poll.now + arm_cycles) : cur.deadline;
    res.fsm_state = st_next;
    res.ready_res = (st_next == ST_IDLE);
  end

endmodule

// ===== hdl/gnss_receiver_init_sequencer.sv =====
// path: the poll register feeds the step logic, which feeds the result register
// throughput: one poll per cycle while the result channel does not stall, set by
//   the single step stage between the poll register and the result register
// reset: synchronous active-high rst returns the sequencer to the hardware
//   reset state with a fresh entry, clears both stage valids and reloads
//   the configuration defaults
// ----------------------------------------------------------------------------
// gnss_receiver_init_sequencer
// bring-up sequencer for a gps receiver: reset hold, serial breaks, baud
// changes, init strings, then idle with a position watchdog
// ----------------------------------------------------------------------------
module gnss_receiver_init_sequencer
  import gris_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // poll channel
  input  logic                 poll_valid,
  output logic                 poll_stall,
  input  poll_t                poll,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t    cfg;
  poll_t   poll_q;       // registered poll transaction
  logic    poll_q_valid;
  seq_t    seq;          // sequencer state
  seq_t    seq_next;
  result_t step_res;
  logic    advance;      // step the poll register into the result register

  // timing and count registers
  gris_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the result register frees up whenever it is empty or being taken, so a
  // finished result stalled downstream holds the poll in flight via poll_stall
  assign advance    = poll_q_valid && (!result_valid || !result_stall);
  assign poll_stall = poll_q_valid && !advance;

  // poll register: refills on the same edge it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
    end else if (!poll_stall) begin
      poll_q_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!poll_stall && poll_valid) begin
      poll_q <= poll;
    end
  end

  // one step of the state machine per registered poll
  gris_step u_step (
    .cur  (seq),
    .poll (poll_q),
    .cfg  (cfg),
    .nxt  (seq_next),
    .res  (step_res)
  );

  // sequencer state only moves when a poll is committed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq.state        <= ST_RESET;
      seq.entering     <= 1'b1;
      seq.deadline     <= '0;
      seq.string_index <= '0;
      seq.prompt_mark  <= '0;
    end else if (advance) begin
      seq <= seq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

endmodule

// ===== hdl/gris_checker.sv =====
// ----------------------------------------------------------------------------
// gris_checker
// port-level checks of the init sequencer result transactions
// ----------------------------------------------------------------------------
`include "gnss_receiver_init_sequencer_assert.svh"

module gris_checker
  import gris_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `GRIS_ASSERT_IMPL(a_ready_is_idle, clk, rst, result_valid, result.ready_res == (result.fsm_state == ST_IDLE))
  `GRIS_ASSERT_IMPL(a_index_quiet, clk, rst, result_valid && !result.send_init, result.init_index == 4'd0)
  `GRIS_ASSERT_IMPL(a_release_to_pause, clk, rst, result_valid && result.release_reset, result.fsm_state == ST_PAUSE0)
  `GRIS_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind gnss_receiver_init_sequencer gris_checker u_gris_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== tb/gris_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gris_scoreboard_pkg
// per-poll action prediction for the init sequencer and in-order checking
// ----------------------------------------------------------------------------
package gris_scoreboard_pkg;
  import gris_pkg::*;

  class sequencer_scoreboard;
    cfg_t        cfg;
    seq_t        st;
    result_t     expected_actions[$];
    bit [10:0]   states_seen;
    int unsigned polls;
    int unsigned results;
    int unsigned reg_writes;
    int unsigned failures;
    int unsigned strings_sent;
    int unsigned baud_timeouts;
    int unsigned init_timeouts;
    int unsigned watchdog_trips;

    function new();
      cfg.reset_wait_cycles  = RST_RESET_WAIT;
      cfg.reply_wait_cycles  = RST_REPLY_WAIT;
      cfg.long_pause_cycles  = RST_LONG_PAUSE;
      cfg.break_cycles       = RST_BREAK;
      cfg.mid_pause_cycles   = RST_MID_PAUSE;
      cfg.short_pause_cycles = RST_SHORT_PAUSE;
      cfg.init_string_count  = RST_STRING_COUNT;
      st.state        = ST_RESET;
      st.entering     = 1'b1;
      st.deadline     = '0;
      st.string_index = '0;
      st.prompt_mark  = '0;
      states_seen     = 11'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      reg_writes++;
      case (idx)
        REG_RESET_WAIT:   cfg.reset_wait_cycles  = data;
        REG_REPLY_WAIT:   cfg.reply_wait_cycles  = data;
        REG_LONG_PAUSE:   cfg.long_pause_cycles  = data;
        REG_BREAK:        cfg.break_cycles       = data;
        REG_MID_PAUSE:    cfg.mid_pause_cycles   = data;
        REG_SHORT_PAUSE:  cfg.short_pause_cycles = data;
        REG_STRING_COUNT: cfg.init_string_count  = data[STR_IDX_W-1:0];
        default: ;
      endcase
    endfunction

    // signed wrap compare against the armed deadline
    function bit due(logic [31:0] now);
      logic [31:0] lag;
      lag = now - st.deadline;
      return !lag[31];
    endfunction

    function seq_state_e timed_pause(logic [31:0] now, logic [31:0] span,
                                     seq_state_e after);
      if (st.entering) begin
        st.deadline = now + span;
        return st.state;
      end
      if (due(now)) return after;
      return st.state;
    endfunction

    function void note_poll(poll_t p);
      result_t    act;
      seq_state_e cur;
      seq_state_e nxt;
      int         lim;
      act = '0;
      cur = st.state;
      nxt = cur;
      polls++;
      case (cur)
        ST_RESET: begin
          if (st.entering) begin
            act.init_ports = 1'b1;
            st.deadline = p.now + cfg.reset_wait_cycles;
          end else if (due(p.now)) begin
            act.release_reset = 1'b1;
            nxt = ST_PAUSE0;
          end
        end
        ST_PAUSE0: nxt = timed_pause(p.now, cfg.long_pause_cycles, ST_BREAK1);
        ST_BREAK1, ST_BREAK2: begin
          if (st.entering) begin
            act.break_control = BRK_START;
            st.deadline = p.now + cfg.break_cycles;
          end else if (due(p.now)) begin
            act.break_control = BRK_END;
            nxt = (cur == ST_BREAK1) ? ST_PAUSE1 : ST_PAUSE2;
          end
        end
        ST_PAUSE1: nxt = timed_pause(p.now, cfg.mid_pause_cycles, ST_BREAK2);
        ST_PAUSE2: nxt = timed_pause(p.now, cfg.short_pause_cycles, ST_COM1);
        ST_PAUSE3: nxt = timed_pause(p.now, cfg.short_pause_cycles, ST_COM2);
        ST_COM1, ST_COM2: begin
          if (st.entering) begin
            st.deadline = p.now + cfg.reply_wait_cycles;
            act.send_baud_cmd = (cur == ST_COM1) ? CMD_COM1 : CMD_COM2;
          end else if (p.com_reply_seen) begin
            // an ack on the deadline poll still wins
            act.apply_baud = (cur == ST_COM1) ? APPLY_COM1 : APPLY_COM2;
            nxt = (cur == ST_COM1) ? ST_PAUSE3 : ST_INIT;
          end else if (due(p.now)) begin
            nxt = ST_RESET;
            baud_timeouts++;
          end
        end
        ST_INIT: begin
          if (st.entering) st.string_index = '0;
          lim = int'(cfg.init_string_count);
          if (lim > MAX_INIT_STRINGS) lim = MAX_INIT_STRINGS;
          if (st.entering || p.prompt_count != st.prompt_mark) begin
            if (int'(st.string_index) < lim) begin
              st.deadline = p.now + cfg.reply_wait_cycles;
              st.prompt_mark = p.prompt_count;
              act.send_init = 1'b1;
              act.init_index = st.string_index[3:0];
              st.string_index = st.string_index + 1'b1;
              strings_sent++;
            end else begin
              nxt = ST_IDLE;
            end
          end else if (due(p.now)) begin
            nxt = ST_RESET;
            init_timeouts++;
          end
        end
        ST_IDLE: begin
          if (st.entering || p.position_msg_seen) begin
            st.deadline = p.now + cfg.long_pause_cycles;
          end else if (due(p.now)) begin
            nxt = ST_RESET;
            watchdog_trips++;
          end
        end
        default: nxt = ST_IDLE;
      endcase
      st.entering = (nxt != cur);
      st.state = nxt;
      states_seen[nxt] = 1'b1;
      act.fsm_state = nxt;
      act.ready_res = (nxt == ST_IDLE);
      expected_actions.push_back(act);
    endfunction

    function int pending();
      return expected_actions.size();
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("result %0d %s: expected %0d, got %0d", results, field, want, got);
      end
    endfunction

    function void check_actions(result_t got);
      result_t want;
      results++;
      if (expected_actions.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result %0d arrived with none outstanding", results);
        return;
      end
      want = expected_actions.pop_front();
      check_field("fsm_state", 32'(want.fsm_state), 32'(got.fsm_state));
      check_field("init_ports", 32'(want.init_ports), 32'(got.init_ports));
      check_field("release_reset", 32'(want.release_reset), 32'(got.release_reset));
      check_field("break_control", 32'(want.break_control), 32'(got.break_control));
      check_field("send_baud_cmd", 32'(want.send_baud_cmd), 32'(got.send_baud_cmd));
      check_field("apply_baud", 32'(want.apply_baud), 32'(got.apply_baud));
      check_field("send_init", 32'(want.send_init), 32'(got.send_init));
      check_field("init_index", 32'(want.init_index), 32'(got.init_index));
      check_field("ready_res", 32'(want.ready_res), 32'(got.ready_res));
    endfunction
  endclass

endpackage

// ===== tb/tb_gnss_receiver_init_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gnss_receiver_init_sequencer
// drives poll transactions through the bring-up sequencer, steering the
// timestamp onto and around each armed deadline so that every state is
// walked, and checks each result against a per-poll prediction
// ----------------------------------------------------------------------------
module tb_gnss_receiver_init_sequencer;
  import gris_pkg::*;
  import gris_scoreboard_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RANDOM_PHASES   = 7;
  localparam int POLLS_PER_PHASE = 150;
  localparam int QUIET_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WALK_LEN        = 25;

  // index past the register file, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // how a poll relates to the armed deadline and the awaited event
  typedef enum {
    AT_DEADLINE,
    SHORT_OF_DEADLINE,
    WITH_REPLY,
    WITH_PROMPT,
    WITH_POSITION,
    NOISE
  } poll_shape_e;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 poll_valid   = 1'b0;
  logic                 poll_stall;
  poll_t                poll         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [31:0]          cfg_data     = '0;

  sequencer_scoreboard sequencer_sb;

  // directed walk: reset hold, both breaks, both baud changes (ack landing
  // on the deadline poll), two strings with prompts on the deadline, then
  // a position message and a watchdog trip back to reset
  poll_shape_e directed_walk [WALK_LEN] = '{
    AT_DEADLINE, SHORT_OF_DEADLINE, AT_DEADLINE,
    AT_DEADLINE, AT_DEADLINE,
    AT_DEADLINE, AT_DEADLINE,
    AT_DEADLINE, AT_DEADLINE,
    AT_DEADLINE, AT_DEADLINE,
    AT_DEADLINE, AT_DEADLINE,
    AT_DEADLINE, WITH_REPLY,
    AT_DEADLINE, AT_DEADLINE,
    AT_DEADLINE, WITH_REPLY,
    AT_DEADLINE, WITH_PROMPT, WITH_PROMPT,
    AT_DEADLINE, WITH_POSITION, AT_DEADLINE
  };

  int unsigned burst_left  = 0;
  int unsigned stall_span  = 0;
  int unsigned stall_mode  = 0;
  int unsigned quiet_count = 0;

  gnss_receiver_init_sequencer uut (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll         (poll),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // receiver back-pressure: segments of no stall, light random stall and
  // heavy stall, each of random length
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 2) == 0);
      default: result_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // result checking and the no-progress watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_count <= 0;
    end else begin
      if (result_valid && !result_stall) sequencer_sb.check_actions(result);
      if ((poll_valid && !poll_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
        $display("no transaction for %0d cycles", QUIET_LIMIT);
        $display("gnss_receiver_init_sequencer: mismatch");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  // one poll transaction; payload holds while stalled
  task automatic send_poll(input poll_t p);
    poll       <= p;
    poll_valid <= 1'b1;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    sequencer_sb.note_poll(p);
  endtask

  task automatic hold_off(input int unsigned cycles);
    poll_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender pauses until every outstanding result is back
  task automatic drain();
    poll_valid <= 1'b0;
    @(posedge clk);
    while (sequencer_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // caller drops cfg_valid after the last write of a batch
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sequencer_sb.write_reg(idx, data);
  endtask

  function automatic logic [31:0] pick_cycles();
    case ($urandom_range(0, 9))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4, 5:    return $urandom;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [4:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'(MAX_INIT_STRINGS + $urandom_range(1, 15));
      default: return 5'($urandom_range(0, 16));
    endcase
  endfunction

  // phase 1 takes every minimum timing with 16 strings, phase 2 every maximum, the rest mix
  task automatic configure(input int phase);
    logic [31:0] count_word;
    count_word = $urandom;
    count_word[4:0] = (phase == 1) ? 5'd16 : (phase == 2) ? 5'd31 : pick_count();
    cfg_write(REG_RESET_WAIT,  (phase == 1) ? 32'd1 : (phase == 2) ? '1 : pick_cycles());
    cfg_write(REG_REPLY_WAIT,  (phase == 1) ? 32'd1 : (phase == 2) ? '1 : pick_cycles());
    cfg_write(REG_LONG_PAUSE,  (phase == 1) ? 32'd1 : (phase == 2) ? '1 : pick_cycles());
    cfg_write(REG_BREAK,       (phase == 1) ? 32'd1 : (phase == 2) ? '1 : pick_cycles());
    cfg_write(REG_MID_PAUSE,   (phase == 1) ? 32'd1 : (phase == 2) ? '1 : pick_cycles());
    cfg_write(REG_SHORT_PAUSE, (phase == 1) ? 32'd1 : (phase == 2) ? '1 : pick_cycles());
    cfg_write(REG_STRING_COUNT, count_word);
    cfg_write(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // build a poll from the predicted state: timestamps land on, just past or just
  // short of the armed deadline, fields the current state ignores are random
  function automatic poll_t shape_poll(input poll_shape_e shape);
    poll_t       p;
    seq_state_e  cur;
    logic [31:0] due_at;
    cur    = sequencer_sb.st.state;
    due_at = sequencer_sb.st.deadline;
    if (sequencer_sb.st.entering) begin
      // entry poll only arms, so any timestamp will do
      case ($urandom_range(0, 7))
        0:       p.now = '0;
        1:       p.now = '1;
        default: p.now = $urandom;
      endcase
    end else begin
      p.now = due_at + $urandom_range(0, 2);
    end
    p.com_reply_seen = (cur == ST_COM1 || cur == ST_COM2) ? 1'b0 : 1'($urandom_range(0, 1));
    p.prompt_count = (cur == ST_INIT) ? sequencer_sb.st.prompt_mark
                                      : 16'($urandom_range(0, 65535));
    p.position_msg_seen = (cur == ST_IDLE) ? 1'b0 : 1'($urandom_range(0, 1));
    case (shape)
      SHORT_OF_DEADLINE: begin
        if (!sequencer_sb.st.entering) p.now = due_at - $urandom_range(1, 3);
      end
      WITH_REPLY:    p.com_reply_seen = 1'b1;
      WITH_PROMPT:   p.prompt_count = sequencer_sb.st.prompt_mark +
                                      16'($urandom_range(1, 65535));
      WITH_POSITION: p.position_msg_seen = 1'b1;
      NOISE: begin
        p.now               = $urandom;
        p.com_reply_seen    = 1'($urandom_range(0, 1));
        p.prompt_count      = 16'($urandom_range(0, 65535));
        p.position_msg_seen = 1'($urandom_range(0, 1));
      end
      default: ;
    endcase
    return p;
  endfunction

  // mostly well-formed progress through the bring-up, some broken polls
  function automatic poll_shape_e pick_shape();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return NOISE;
    case (sequencer_sb.st.state)
      ST_COM1, ST_COM2:
        return (roll < 60) ? WITH_REPLY : (roll < 80) ? SHORT_OF_DEADLINE : AT_DEADLINE;
      ST_INIT:
        return (roll < 70) ? WITH_PROMPT : (roll < 88) ? SHORT_OF_DEADLINE : AT_DEADLINE;
      ST_IDLE:
        return (roll < 35) ? WITH_POSITION : (roll < 75) ? SHORT_OF_DEADLINE : AT_DEADLINE;
      default:
        return (roll < 70) ? AT_DEADLINE : SHORT_OF_DEADLINE;
    endcase
  endfunction

  // sender bursts: random length, occasional long gap-free stretches
  task automatic paced_poll(input poll_shape_e shape);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
    burst_left--;
    send_poll(shape_poll(shape));
  endtask

  initial begin
    int unsigned drain_at;
    int          fails;
    sequencer_sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed walk on reset timing values, two init strings
    cfg_write(REG_STRING_COUNT, 32'd2);
    cfg_valid <= 1'b0;
    foreach (directed_walk[i]) paced_poll(directed_walk[i]);
    drain();

    // random phases, each under its own register setting
    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      configure(phase);
      drain_at = $urandom_range(10, POLLS_PER_PHASE - 10);
      for (int n = 0; n < POLLS_PER_PHASE; n++) begin
        if (n == drain_at) drain();
        paced_poll(pick_shape());
      end
      drain();
    end

    fails = sequencer_sb.failures + sequencer_sb.pending();
    $display("%0d polls, %0d results, %0d register writes, %0d of 11 states reached",
             sequencer_sb.polls, sequencer_sb.results, sequencer_sb.reg_writes,
             $countones(sequencer_sb.states_seen));
    $display("%0d init strings sent; timeouts: baud %0d, init %0d, idle watchdog %0d",
             sequencer_sb.strings_sent, sequencer_sb.baud_timeouts,
             sequencer_sb.init_timeouts, sequencer_sb.watchdog_trips);
    if (fails == 0) begin
      $display("gnss_receiver_init_sequencer: match");
    end else begin
      $display("gnss_receiver_init_sequencer: mismatch");
    end
    $finish;
  end

endmodule
